// File: src/rcst_pkg.sv
// ----------------------------------------------------------------------------
// rcst_pkg
// shared types, codes and defaults for the reference-counted slot table
// ----------------------------------------------------------------------------
package rcst_pkg;

  // default sizes
  localparam int SLOTS_DEF      = 256;
  localparam int COUNT_BITS_DEF = 32;

  // configuration port
  localparam int          CFG_AW           = 3;
  localparam logic        REG_SLOTS_IN_USE = 1'b0;
  localparam logic [8:0]  SLOTS_IN_USE_RST = 9'd256;

  // request actions
  localparam logic [1:0] ACT_NEW = 2'd0;
  localparam logic [1:0] ACT_GET = 2'd1;
  localparam logic [1:0] ACT_REL = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_FAIL    = 2'd2;
  localparam logic [1:0] ST_BAD_ID  = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] slot_id;
    logic       auto_release;
    logic       upload_ok;
  } rcst_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  granted_slot;
    logic [31:0] count_after;
    logic        slot_freed;
  } rcst_rsp_t;

endpackage

// File: src/refcounted_slot_table_top.sv
// ----------------------------------------------------------------------------
// refcounted_slot_table_top
// slot table with valid marks, reference counts and auto-release marks
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                     payload
// request   in         start & !busy                 in_data  (rcst_req_t)
// result    out        out_valid, one cycle, no stall out_data (rcst_rsp_t)
// config    in         psel & penable & pwrite       pwdata, paddr (apb style)
//
// a request is taken only while busy is low: the accept cycle reads the
// count memory and picks the lowest group with a free slot, the execute
// cycle (busy high) finds the slot in that group and writes the memory back
// the result shows in the cycle after execute, as the next request is taken
// reset is synchronous: valid marks cleared, slots_in_use back to 256; the
// count memory needs no clearing pass, a slot's count is only read while valid
// the receiver cannot stall, so nothing ever backs up on the result side
// ----------------------------------------------------------------------------
module refcounted_slot_table_top import rcst_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              start,
  output logic              busy,
  input  rcst_req_t         in_data,
  // result channel
  output logic              out_valid,
  output rcst_rsp_t         out_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // slot ids are 8 bits, so at most 256 slots are ever reachable
  localparam int NV  = (SLOTS < 256) ? SLOTS : 256;
  localparam int VW  = (NV > 1) ? $clog2(NV) : 1;
  // free search: groups of 16 slots, group picked in the accept cycle
  localparam int GW  = 16;
  localparam int NG  = (NV + GW - 1) / GW;
  localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
  localparam int NGP = 1 << GIW;
  localparam int PW  = NGP * GW;
  // memory word: auto-release mark on top of the count
  localparam int MW  = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // control and configuration state
  logic [8:0]            slots_in_use_r;
  logic [NV-1:0]         valid_r;
  logic                  exec_r;
  logic                  out_valid_r;
  rcst_rsp_t             out_r;

  // request held for the execute cycle
  rcst_req_t             req_r;
  logic [GIW-1:0]        grp_r;
  logic                  gfound_r;
  logic                  id_ok_r;
  logic                  hit_r;

  // count memory
  logic [MW-1:0]         cnt_mem [NV];
  logic [MW-1:0]         rd_r;
  logic                  mem_we;
  logic [VW-1:0]         mem_wa;
  logic [MW-1:0]         mem_wd;

  logic                  acc;
  logic                  cfg_we;
  logic [VW-1:0]         id_idx;
  logic                  id_ok;
  logic [PW-1:0]         free_pad;
  logic [NGP-1:0]        grp_any;
  logic [GIW-1:0]        grp_sel;
  logic [GW-1:0]         in_grp;
  logic [3:0]            lo_sel;
  logic [12:0]           slot_w;
  logic [VW-1:0]         new_idx;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  rd_auto;
  logic [COUNT_BITS-1:0] cnt_upd;
  logic [63:0]           cnt_ext;
  logic                  v_set;
  logic                  v_clr;
  logic [VW-1:0]         v_idx;
  rcst_rsp_t             rsp_nxt;

  assign acc       = start && !busy;
  assign busy      = exec_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[CFG_AW-1:2] == REG_SLOTS_IN_USE);
  assign prdata = (paddr[CFG_AW-1:2] == REG_SLOTS_IN_USE) ? 32'(slots_in_use_r) : 32'd0;

  // ---------------- id decode ----------------
  assign id_ok  = (32'(in_data.slot_id) < NV);
  assign id_idx = VW'(in_data.slot_id);

  // ---------------- free search ----------------
  // free means not valid and under the active limit, padding reads as taken
  genvar gi;
  generate
    for (gi = 0; gi < PW; gi++) begin : g_free
      if (gi < NV) begin : g_live
        assign free_pad[gi] = !valid_r[gi] && (9'(gi) < slots_in_use_r);
      end else begin : g_pad
        assign free_pad[gi] = 1'b0;
      end
    end
    for (gi = 0; gi < NGP; gi++) begin : g_grp
      assign grp_any[gi] = |free_pad[gi*GW +: GW];
    end
  endgenerate

  // lowest group with a free slot
  always_comb begin
    grp_sel = '0;
    for (int g = NGP - 1; g >= 0; g--) begin
      if (grp_any[g]) grp_sel = GIW'(g);
    end
  end

  // lowest free slot inside the chosen group
  assign in_grp = free_pad[grp_r*GW +: GW];
  always_comb begin
    lo_sel = '0;
    for (int b = GW - 1; b >= 0; b--) begin
      if (in_grp[b]) lo_sel = 4'(b);
    end
  end

  assign slot_w  = 13'({grp_r, lo_sel});
  assign new_idx = slot_w[VW-1:0];

  // ---------------- accept cycle ----------------
  always_ff @(posedge clk) begin
    if (acc) begin
      req_r    <= in_data;
      grp_r    <= grp_sel;
      gfound_r <= |grp_any;
      id_ok_r  <= id_ok;
      hit_r    <= id_ok && valid_r[id_idx];
      rd_r     <= cnt_mem[id_idx];
    end
  end

  // ---------------- execute cycle ----------------
  assign rd_cnt  = rd_r[COUNT_BITS-1:0];
  assign rd_auto = rd_r[COUNT_BITS];
  assign cnt_ext = 64'(cnt_upd);

  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = VW'(req_r.slot_id);
    mem_wd  = rd_r;
    v_set   = 1'b0;
    v_clr   = 1'b0;
    v_idx   = VW'(req_r.slot_id);
    cnt_upd = rd_cnt;
    rsp_nxt = '{status: ST_BAD_ID, granted_slot: req_r.slot_id,
                count_after: 32'd0, slot_freed: 1'b0};
    unique case (req_r.action)
      ACT_NEW: begin
        cnt_upd = CNT_ONE;
        if (!gfound_r) begin
          rsp_nxt = '{status: ST_NO_FREE, granted_slot: 8'd0,
                      count_after: 32'd0, slot_freed: 1'b0};
        end else if (!req_r.upload_ok) begin
          // creation failed: slot stays free
          rsp_nxt = '{status: ST_FAIL, granted_slot: slot_w[7:0],
                      count_after: 32'd0, slot_freed: 1'b0};
        end else begin
          mem_we  = exec_r;
          mem_wa  = new_idx;
          mem_wd  = {req_r.auto_release, CNT_ONE};
          v_set   = 1'b1;
          v_idx   = new_idx;
          rsp_nxt = '{status: ST_OK, granted_slot: slot_w[7:0],
                      count_after: cnt_ext[31:0], slot_freed: 1'b0};
        end
      end
      ACT_GET: begin
        if (id_ok_r && hit_r) begin
          // saturating increment
          cnt_upd = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CNT_ONE;
          mem_we  = exec_r;
          mem_wd  = {rd_auto, cnt_upd};
          rsp_nxt = '{status: ST_OK, granted_slot: req_r.slot_id,
                      count_after: cnt_ext[31:0], slot_freed: 1'b0};
        end
      end
      ACT_REL: begin
        if (id_ok_r && hit_r) begin
          cnt_upd = (rd_cnt != '0) ? rd_cnt - CNT_ONE : rd_cnt;
          mem_we  = exec_r;
          if (cnt_upd == '0 && rd_auto) begin
            // auto-release: slot goes back to the free pool
            mem_wd  = '0;
            v_clr   = 1'b1;
            rsp_nxt = '{status: ST_OK, granted_slot: req_r.slot_id,
                        count_after: 32'd0, slot_freed: 1'b1};
          end else begin
            mem_wd  = {rd_auto, cnt_upd};
            rsp_nxt = '{status: ST_OK, granted_slot: req_r.slot_id,
                        count_after: cnt_ext[31:0], slot_freed: 1'b0};
          end
        end
      end
      default: begin
        // unused action code: rejected, nothing changes
        rsp_nxt = '{status: ST_BAD_ID, granted_slot: req_r.slot_id,
                    count_after: 32'd0, slot_freed: 1'b0};
      end
    endcase
  end

  // count memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (exec_r) begin
      out_r <= rsp_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= SLOTS_IN_USE_RST;
      valid_r        <= '0;
      exec_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      exec_r      <= acc;
      out_valid_r <= exec_r;
      if (cfg_we) begin
        slots_in_use_r <= pwdata[8:0];
      end
      if (exec_r && v_set) begin
        valid_r[v_idx] <= 1'b1;
      end
      if (exec_r && v_clr) begin
        valid_r[v_idx] <= 1'b0;
      end
    end
  end

  // ---------------- assertions ----------------
  // an execute cycle is never directly followed by another
  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("execute cycle lasted more than one cycle");

  // a result only follows an execute cycle
  a_rsp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(exec_r))
    else $error("result without execute cycle");

  // a successful non-freeing request leaves its slot valid
  a_ok_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_OK && !out_data.slot_freed)
      |-> valid_r[out_data.granted_slot[VW-1:0]])
    else $error("granted slot not valid");

  // a freed slot is no longer valid
  a_freed_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.slot_freed) |-> !valid_r[out_data.granted_slot[VW-1:0]])
    else $error("freed slot still valid");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the reference-counted slot table: a shadow copy of
// the slot table predicts every result at accept time, a monitor compares the
// results field by field in order, and configuration writes land only when
// the table is idle
// ----------------------------------------------------------------------------
module tb;
  import rcst_pkg::*;

  localparam int          SLOTS        = SLOTS_DEF;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;       // action code the table rejects
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          PHASE_ITEMS  = 200;
  localparam int          TAIL_CYCLES  = 8;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // request channel
  logic      start   = 1'b0;
  logic      busy;
  rcst_req_t in_data = '0;

  // result channel
  logic      out_valid;
  rcst_rsp_t out_data;

  // configuration port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  // shadow of the slot table and its register
  bit          shadow_valid [SLOTS];
  logic [31:0] shadow_count [SLOTS];
  bit          shadow_auto  [SLOTS];
  logic [8:0]  shadow_slots_in_use;

  // predicted results, oldest first
  rcst_rsp_t   outcome_q[$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          quiet       = 1'b0;   // no idle bursts in the closing stretch

  refcounted_slot_table_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[refcounted_slot_table_top] ERROR");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // prediction: applies one request to the shadow table and returns the
  // result the block should give for it
  // ---------------------------------------------------------------------------
  function automatic rcst_rsp_t slot_op_outcome(input rcst_req_t r);
    rcst_rsp_t o;
    int        limit;
    int        i;
    o = '0;
    if (r.action == ACT_NEW) begin
      // register above the table size saturates, zero means nothing can be taken
      limit = (int'(shadow_slots_in_use) < SLOTS) ? int'(shadow_slots_in_use) : SLOTS;
      i = 0;
      while (i < limit && shadow_valid[i]) i++;
      if (i >= limit) begin
        o.status = ST_NO_FREE;
      end else if (!r.upload_ok) begin
        // creation failed: the slot that was tried stays free
        o.status       = ST_FAIL;
        o.granted_slot = 8'(i);
      end else begin
        shadow_valid[i] = 1'b1;
        shadow_count[i] = 32'd1;
        shadow_auto[i]  = r.auto_release;
        o.status        = ST_OK;
        o.granted_slot  = 8'(i);
        o.count_after   = 32'd1;
      end
      return o;
    end
    o.granted_slot = r.slot_id;
    // unknown action or a slot not in use: rejected, nothing changes;
    // slots above the active limit stay addressable by id
    if ((r.action != ACT_GET && r.action != ACT_REL) || !shadow_valid[r.slot_id]) begin
      o.status = ST_BAD_ID;
      return o;
    end
    o.status = ST_OK;
    if (r.action == ACT_GET) begin
      // count saturates at all ones
      if (shadow_count[r.slot_id] != '1) shadow_count[r.slot_id]++;
      o.count_after = shadow_count[r.slot_id];
    end else begin
      if (shadow_count[r.slot_id] != '0) shadow_count[r.slot_id]--;
      if (shadow_count[r.slot_id] == '0 && shadow_auto[r.slot_id]) begin
        shadow_valid[r.slot_id] = 1'b0;
        shadow_auto[r.slot_id]  = 1'b0;
        o.slot_freed            = 1'b1;
      end else begin
        // count zero without auto-release keeps the slot in use
        o.count_after = shadow_count[r.slot_id];
      end
    end
    return o;
  endfunction

  function automatic rcst_req_t mk_req(input logic [1:0] act, input logic [7:0] id,
                                       input logic auto_rel, input logic ok);
    rcst_req_t r;
    r.action       = act;
    r.slot_id      = id;
    r.auto_release = auto_rel;
    r.upload_ok    = ok;
    return r;
  endfunction

  // random idle burst ahead of a request, none in the closing stretch
  function automatic int idle_gap();
    if (quiet || $urandom_range(0, 4) != 0) return 0;
    return $urandom_range(1, 16);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: start is raised at a clock edge and stays high until the
  // edge where busy was low; start is never lowered and raised in one step
  // ---------------------------------------------------------------------------
  task automatic issue_request(input rcst_req_t r);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy !== 1'b0);
    // accepted at this edge: predict now, before the block can answer
    outcome_q.push_back(slot_op_outcome(r));
  endtask

  // every request gives a result, so once the queue is empty the table is idle
  task automatic wait_drained();
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // register write followed by a read-back, only with the table idle
  // ---------------------------------------------------------------------------
  task automatic write_slots_in_use(input logic [8:0] value);
    wait_drained();
    // write: setup then access
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * int'(REG_SLOTS_IN_USE));
    pwdata  <= {23'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready !== 1'b1) note_mismatch("pready low in write access");
    shadow_slots_in_use = value;
    // read back: setup then access
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {23'd0, shadow_slots_in_use})
      note_mismatch($sformatf("slots_in_use read back: expected %0d actual %0h",
                              shadow_slots_in_use, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result monitor: one result per out_valid cycle, checked against the oldest
  // prediction field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rcst_rsp_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (outcome_q.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: status %0d slot %0d count %0d freed %0b",
                                out_data.status, out_data.granted_slot,
                                out_data.count_after, out_data.slot_freed));
      end else begin
        want = outcome_q.pop_front();
        if (out_data.status       !== want.status       ||
            out_data.granted_slot !== want.granted_slot ||
            out_data.count_after  !== want.count_after  ||
            out_data.slot_freed   !== want.slot_freed)
          note_mismatch($sformatf(
            "expected status %0d slot %0d count %0d freed %0b, actual %0d %0d %0d %0b",
            want.status, want.granted_slot, want.count_after, want.slot_freed,
            out_data.status, out_data.granted_slot, out_data.count_after,
            out_data.slot_freed));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every action and the corner cases on a fresh table, reset register value
  task automatic test_directed();
    issue_request(mk_req(ACT_REL,    8'h00, 1'b0, 1'b0));  // slot not in use
    issue_request(mk_req(ACT_GET,    8'hFF, 1'b1, 1'b1));  // top id, not in use
    issue_request(mk_req(ACT_UNUSED, 8'hAA, 1'b0, 1'b1));  // unknown action
    issue_request(mk_req(ACT_NEW,    8'h00, 1'b1, 1'b0));  // creation failed
    issue_request(mk_req(ACT_NEW,    8'h55, 1'b1, 1'b1));  // slot 0, auto-release
    issue_request(mk_req(ACT_GET,    8'h00, 1'b0, 1'b0));
    issue_request(mk_req(ACT_REL,    8'h00, 1'b0, 1'b0));
    issue_request(mk_req(ACT_REL,    8'h00, 1'b0, 1'b0));  // drops to zero, freed
    issue_request(mk_req(ACT_REL,    8'h00, 1'b0, 1'b0));  // already free
    issue_request(mk_req(ACT_NEW,    8'hFF, 1'b0, 1'b1));  // slot 0, kept at zero
    issue_request(mk_req(ACT_NEW,    8'h00, 1'b1, 1'b1));  // slot 1
    issue_request(mk_req(ACT_REL,    8'h00, 1'b1, 1'b1));  // count zero, still valid
    issue_request(mk_req(ACT_REL,    8'h00, 1'b0, 1'b0));  // zero count, no auto-release
    issue_request(mk_req(ACT_GET,    8'h00, 1'b0, 1'b0));
    issue_request(mk_req(ACT_UNUSED, 8'h00, 1'b1, 1'b1));  // unknown action on a valid slot
    issue_request(mk_req(ACT_REL,    8'h01, 1'b0, 1'b0));  // slot 1 freed
    issue_request(mk_req(ACT_NEW,    8'h00, 1'b0, 1'b0));  // fail on slot 1
    issue_request(mk_req(ACT_NEW,    8'hFF, 1'b0, 1'b1));  // slot 1 again
  endtask

  // register above the table size, then fill every slot up to the top one
  task automatic test_full_table();
    write_slots_in_use(9'd511);
    repeat (SLOTS + 2) issue_request(mk_req(ACT_NEW, 8'($urandom), 1'b1, 1'b1));
    issue_request(mk_req(ACT_GET, 8'hFF, 1'b0, 1'b0));
    issue_request(mk_req(ACT_REL, 8'hFF, 1'b0, 1'b0));
    issue_request(mk_req(ACT_REL, 8'hFF, 1'b0, 1'b0));    // top slot freed
    issue_request(mk_req(ACT_NEW, 8'h00, 1'b0, 1'b1));    // lands on the top slot
  endtask

  // small and zero limits; slots above the limit stay addressable
  task automatic test_limits();
    write_slots_in_use(9'd2);
    issue_request(mk_req(ACT_NEW, 8'h00, 1'b1, 1'b1));    // no free slot
    issue_request(mk_req(ACT_GET, 8'd200, 1'b0, 1'b0));
    issue_request(mk_req(ACT_REL, 8'd200, 1'b0, 1'b0));
    write_slots_in_use(9'd0);
    issue_request(mk_req(ACT_NEW, 8'h00, 1'b1, 1'b1));
    issue_request(mk_req(ACT_NEW, 8'h00, 1'b0, 1'b0));
    issue_request(mk_req(ACT_GET, 8'd100, 1'b0, 1'b0));
    write_slots_in_use(9'd1);
    issue_request(mk_req(ACT_NEW, 8'h00, 1'b1, 1'b1));
    write_slots_in_use(9'd256);
    issue_request(mk_req(ACT_NEW, 8'h00, 1'b1, 1'b1));
  endtask

  // mostly a slot in use, so gets and releases reach past the id check
  function automatic logic [7:0] pick_slot();
    int first;
    int k;
    first = $urandom_range(0, SLOTS - 1);
    if ($urandom_range(0, 9) < 7) begin
      for (k = 0; k < SLOTS; k++)
        if (shadow_valid[(first + k) % SLOTS]) return 8'((first + k) % SLOTS);
    end
    return 8'(first);
  endfunction

  function automatic rcst_req_t random_request();
    int         sel;
    logic [1:0] act;
    sel = $urandom_range(0, 99);
    if (sel < 35)      act = ACT_NEW;
    else if (sel < 65) act = ACT_GET;
    else if (sel < 96) act = ACT_REL;
    else               act = ACT_UNUSED;
    return mk_req(act, (act == ACT_NEW) ? 8'($urandom) : pick_slot(),
                  $urandom_range(0, 9) < 8, $urandom_range(0, 9) < 8);
  endfunction

  // phases under different register values; the last one runs without idling
  task automatic test_random();
    logic [8:0] limits [10];
    int p;
    limits = '{9'd256, 9'd3, 9'd16, 9'd0, 9'd64, 9'd511, 9'd1, 9'd2, 9'd300, 9'd256};
    for (p = 0; p < 10; p++) begin
      write_slots_in_use(limits[p]);
      quiet = (p == 9);
      repeat (PHASE_ITEMS) issue_request(random_request());
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence: reset once, run the tests, drain, report
  // ---------------------------------------------------------------------------
  initial begin
    int k;
    for (k = 0; k < SLOTS; k++) begin
      shadow_valid[k] = 1'b0;
      shadow_count[k] = '0;
      shadow_auto[k]  = 1'b0;
    end
    shadow_slots_in_use = SLOTS_IN_USE_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_table();
    test_limits();
    test_random();

    // all results in, then a tail wait to catch stray strobes
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[refcounted_slot_table_top] OK");
    end else begin
      $display("[refcounted_slot_table_top] ERROR");
    end
    $finish;
  end

endmodule
